[src/mstb_pkg.sv]
// ----------------------------------------------------------------------------
// mstb_pkg: shared types and constants for the soft timer bank
// Field widths, command codes and the per-timer control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mstb_pkg;

  localparam int NumTimers = 8;   // timers built, 1..8
  localparam int MapW      = 8;   // width of the done / active maps
  localparam int IdxW      = 3;
  localparam int TicksW    = 15;  // delay and elapsed fields
  localparam int CountW    = 16;  // count and reload storage

  localparam logic [MapW-1:0] DoneResetMap = 8'hff;

  typedef enum logic [1:0] {
    ModeTick    = 2'd0,
    ModeOneShot = 2'd1,
    ModeRecur   = 2'd2,
    ModeArm     = 2'd3
  } mode_e;

  typedef struct packed {
    logic tick;      // subtract elapsed, reload on expiry
    logic load_cnt;  // count <= delay
    logic load_rld;  // reload <= delay
  } lane_ctrl_t;

endpackage : mstb_pkg

`default_nettype wire

[src/mstb_if.sv]
// ----------------------------------------------------------------------------
// mstb_if: command and result channels of the soft timer bank
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstb_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [mstb_pkg::IdxW-1:0]   timer_index;
  logic [mstb_pkg::TicksW-1:0] delay_ticks;
  logic [mstb_pkg::TicksW-1:0] elapsed_ticks;

  modport source (output valid, mode, timer_index, delay_ticks, elapsed_ticks,
                  input ready);
  modport sink (input valid, mode, timer_index, delay_ticks, elapsed_ticks,
                output ready);
endinterface : mstb_cmd_if

interface mstb_res_if;
  logic                      valid;
  logic                      ready;
  logic [mstb_pkg::MapW-1:0] done_map;
  logic [mstb_pkg::MapW-1:0] active_map;
  logic                      selected_done;

  modport source (output valid, done_map, active_map, selected_done,
                  input ready);
  modport sink (input valid, done_map, active_map, selected_done,
                output ready);
endinterface : mstb_res_if

`default_nettype wire

[src/multi_channel_soft_timer_bank.sv]
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank: eight countdown timers, one-shot or periodic
// Command-driven timer bank reporting done and active maps per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command per transfer: tick (subtract elapsed_ticks from
//   every running timer), start one-shot (zero delay stops the timer), start
//   recurring, or arm (clear a done bit). res_o returns one result per
//   command: the done and active maps after the update and the done bit of
//   the addressed timer.
//   A command transfer is captured in the command register; the update runs
//   from there and lands in the result register, which drives res_o.
//   Throughput is one command per cycle while res_o is not stalled; the whole
//   update is a single pass through eight parallel compare/subtract lanes.
//   A stalled res_o holds its result; the command register still takes one
//   more command, after which cmd_i.ready drops until the result is taken.
//   Reset clears all running timers and sets every done bit; count and
//   reload values are undefined until a start command writes them.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_soft_timer_bank (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mstb_cmd_if.sink    cmd_i,
  mstb_res_if.source  res_o
);

  localparam int N = mstb_pkg::NumTimers;
  localparam int W = mstb_pkg::MapW;

  // command register
  logic                        cmd_vld_q;
  mstb_pkg::mode_e             mode_q;
  logic [mstb_pkg::IdxW-1:0]   idx_q;
  logic [mstb_pkg::TicksW-1:0] delay_q;
  logic [mstb_pkg::TicksW-1:0] elapsed_q;

  // timer state
  logic [W-1:0] done_q, done_d;
  logic [W-1:0] active_q, active_d;
  logic [W-1:0] recur_q, recur_d;

  // result register
  logic         res_vld_q;
  logic [W-1:0] res_done_q, res_active_q;
  logic         res_sel_q;

  logic         advance;
  logic         cmd_take;
  logic         idx_ok;
  logic         do_tick;
  logic [W-1:0] sel_oh;
  logic [W-1:0] expired;

  mstb_pkg::lane_ctrl_t lane_ctrl [N];

  assign advance  = cmd_vld_q && (!res_vld_q || res_o.ready);
  assign cmd_i.ready = !cmd_vld_q || advance;
  assign cmd_take = cmd_i.valid && cmd_i.ready;

  assign idx_ok  = {1'b0, idx_q} < (mstb_pkg::IdxW+1)'(N);
  assign sel_oh  = idx_ok ? (W'(1) << idx_q) : '0;
  assign do_tick = (mode_q == mstb_pkg::ModeTick) && (elapsed_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      mode_q    <= mstb_pkg::mode_e'(cmd_i.mode);
      idx_q     <= cmd_i.timer_index;
      delay_q   <= cmd_i.delay_ticks;
      elapsed_q <= cmd_i.elapsed_ticks;
    end
  end

  // per-timer lanes
  for (genvar t = 0; t < W; t++) begin : g_lane
    if (t < N) begin : g_on
      always_comb begin
        lane_ctrl[t].tick     = advance && do_tick && active_q[t];
        lane_ctrl[t].load_cnt = advance && sel_oh[t] &&
                                (((mode_q == mstb_pkg::ModeOneShot) && (delay_q != '0)) ||
                                 (mode_q == mstb_pkg::ModeRecur));
        lane_ctrl[t].load_rld = advance && sel_oh[t] && (mode_q == mstb_pkg::ModeRecur);
      end

      mstb_timer_lane u_lane (
        .clk_i     (clk_i),
        .ctrl_i    (lane_ctrl[t]),
        .delay_i   (delay_q),
        .elapsed_i (elapsed_q),
        .expired_o (expired[t])
      );
    end else begin : g_off
      assign expired[t] = 1'b0;
    end
  end

  always_comb begin
    done_d   = done_q;
    active_d = active_q;
    recur_d  = recur_q;
    if (advance) begin
      unique case (mode_q)
        mstb_pkg::ModeTick: begin
          if (do_tick) begin
            for (int t = 0; t < N; t++) begin
              if (active_q[t] && expired[t]) begin
                done_d[t] = 1'b1;
                if (!recur_q[t]) active_d[t] = 1'b0;
              end
            end
          end
        end
        mstb_pkg::ModeOneShot: begin
          recur_d = recur_q & ~sel_oh;
          if (delay_q != '0) begin
            done_d   = done_q & ~sel_oh;
            active_d = active_q | sel_oh;
          end else begin
            done_d   = done_q | sel_oh;
            active_d = active_q & ~sel_oh;
          end
        end
        mstb_pkg::ModeRecur: begin
          active_d = active_q | sel_oh;
          recur_d  = recur_q | sel_oh;
        end
        mstb_pkg::ModeArm: begin
          done_d = done_q & ~sel_oh;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= mstb_pkg::DoneResetMap;
      active_q <= '0;
      recur_q  <= '0;
    end else begin
      done_q   <= done_d;
      active_q <= active_d;
      recur_q  <= recur_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_done_q   <= done_d;
      res_active_q <= active_d;
      res_sel_q    <= done_d[idx_q];
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.done_map      = res_done_q;
  assign res_o.active_map    = res_active_q;
  assign res_o.selected_done = res_sel_q;

  // a recurring timer is always running
  a_recur_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (recur_q & ~active_q) == '0)
    else $error("recurring flag set on an idle timer");

  // a tick never clears a done bit
  a_tick_keeps_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_q == mstb_pkg::ModeTick) |=> (done_q & $past(done_q)) == $past(done_q))
    else $error("tick cleared a done bit");

  // a tick of zero ticks changes nothing
  a_zero_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_q == mstb_pkg::ModeTick) && (elapsed_q == '0)
    |=> $stable(active_q) && $stable(done_q))
    else $error("zero-length tick changed timer state");

  // result register loads only from a completed update
  a_res_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(cmd_vld_q))
    else $error("result without a command");

endmodule : multi_channel_soft_timer_bank

`default_nettype wire

[src/mstb_timer_lane.sv]
// ----------------------------------------------------------------------------
// mstb_timer_lane: count and reload storage of one timer
// Loads on start commands, counts down on ticks and flags expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module mstb_timer_lane (
  input  wire logic                        clk_i,
  input  wire mstb_pkg::lane_ctrl_t        ctrl_i,
  input  wire logic [mstb_pkg::TicksW-1:0] delay_i,
  input  wire logic [mstb_pkg::TicksW-1:0] elapsed_i,
  output logic                             expired_o
);

  logic [mstb_pkg::CountW-1:0] count_q, count_d;
  logic [mstb_pkg::CountW-1:0] reload_q, reload_d;
  logic [mstb_pkg::CountW-1:0] elapsed_ext;

  assign elapsed_ext = {1'b0, elapsed_i};

  // count is signed: negative or not above elapsed means expired
  assign expired_o = count_q[mstb_pkg::CountW-1] || (count_q <= elapsed_ext);

  always_comb begin
    count_d  = count_q;
    reload_d = reload_q;
    if (ctrl_i.load_cnt) begin
      count_d = {1'b0, delay_i};
    end else if (ctrl_i.tick) begin
      count_d = expired_o ? reload_q : (count_q - elapsed_ext);
    end
    if (ctrl_i.load_rld) begin
      reload_d = {1'b0, delay_i};
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    reload_q <= reload_d;
  end

endmodule : mstb_timer_lane

`default_nettype wire
